// File: src/unack_mode_sdu_segmenter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segmenter; each expects i_clk and
// i_rst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef UNACK_MODE_SDU_SEGMENTER_ASSERT_SVH
`define UNACK_MODE_SDU_SEGMENTER_ASSERT_SVH

// same-cycle implication
`define USDU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segmenter check failed");

// next-cycle implication
`define USDU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segmenter check failed");

`endif

// File: src/usdu_pkg.sv
// ---------------------------------------------------------------------------
// usdu_pkg
// Types and constants shared by the segmenter modules.
// ---------------------------------------------------------------------------
package usdu_pkg;

    localparam int DEF_LENGTH_WIDTH = 16;
    localparam int DEF_QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd1024;
    localparam logic [7:0]  RST_CODE_COMPLETE = 8'd0;
    localparam logic [7:0]  RST_CODE_FIRST    = 8'd1;
    localparam logic [7:0]  RST_CODE_MIDDLE   = 8'd2;
    localparam logic [7:0]  RST_CODE_LAST     = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PAYLOAD   = 3'd0,
        CFG_CODE_COMPLETE = 3'd1,
        CFG_CODE_FIRST    = 3'd2,
        CFG_CODE_MIDDLE   = 3'd3,
        CFG_CODE_LAST     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_CODE   = 2'd0,
        PH_SEQ_LO = 2'd1,
        PH_SEQ_HI = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    // one classified item, ready for emission
    typedef struct packed {
        logic        hdr;
        logic [7:0]  code;
        logic [15:0] seq;
        logic [7:0]  data;
        logic        pend;
    } t_desc;

endpackage

// File: src/usdu_front.sv
// ---------------------------------------------------------------------------
// usdu_front
// Holds the configuration registers and the unit/segment state; classifies
// each accepted byte into a descriptor for the emitter.
// ---------------------------------------------------------------------------
module usdu_front
    import usdu_pkg::*;
#(
    parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic [15:0]           i_sdu_length,
    output logic                  o_push,
    output t_desc                 o_desc,
    input  logic                  i_q_ready
);

    localparam int CmpW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;

    logic [15:0]             r_max_payload;
    logic [7:0]              r_code_complete;
    logic [7:0]              r_code_first;
    logic [7:0]              r_code_middle;
    logic [7:0]              r_code_last;

    logic [15:0]             r_seq;
    logic [LENGTH_WIDTH-1:0] r_bytes_left;
    logic [15:0]             r_fill;
    logic                    r_split;
    logic                    r_first;

    logic [15:0]             maxp;
    logic [CmpW-1:0]         maxp_ext;
    logic [CmpW-1:0]         len_ext;
    logic [LENGTH_WIDTH-1:0] len_t;
    logic                    opening;
    logic                    drop;
    logic [LENGTH_WIDTH-1:0] bl_cur;
    logic [15:0]             fill_cur;
    logic                    split_cur;
    logic                    first_cur;
    logic                    hdr;
    logic                    pend;
    logic [7:0]              code;
    logic                    fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload   <= RST_MAX_PAYLOAD;
            r_code_complete <= RST_CODE_COMPLETE;
            r_code_first    <= RST_CODE_FIRST;
            r_code_middle   <= RST_CODE_MIDDLE;
            r_code_last     <= RST_CODE_LAST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_PAYLOAD:   r_max_payload   <= i_cfg_wdata;
                CFG_CODE_COMPLETE: r_code_complete <= i_cfg_wdata[7:0];
                CFG_CODE_FIRST:    r_code_first    <= i_cfg_wdata[7:0];
                CFG_CODE_MIDDLE:   r_code_middle   <= i_cfg_wdata[7:0];
                CFG_CODE_LAST:     r_code_last     <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        maxp      = (r_max_payload == 16'd0) ? 16'd1 : r_max_payload;
        maxp_ext  = CmpW'(maxp);
        len_ext   = CmpW'(i_sdu_length);
        len_t     = len_ext[LENGTH_WIDTH-1:0];
        opening   = (r_bytes_left == '0);
        drop      = opening && (len_t == '0);
        bl_cur    = opening ? len_t : r_bytes_left;
        fill_cur  = opening ? 16'd0 : r_fill;
        split_cur = opening ? (CmpW'(len_t) > maxp_ext) : r_split;
        first_cur = opening ? 1'b1 : r_first;
        hdr       = (fill_cur == 16'd0);
        pend      = (bl_cur == LENGTH_WIDTH'(1))
                    || (({1'b0, fill_cur} + 17'd1) >= {1'b0, maxp});
        if (!split_cur) begin
            code = r_code_complete;
        end else if (first_cur) begin
            code = r_code_first;
        end else if (CmpW'(bl_cur) <= maxp_ext) begin
            code = r_code_last;
        end else begin
            code = r_code_middle;
        end
    end

    assign o_in_ready  = i_q_ready;
    assign fire        = i_in_valid && i_q_ready;
    assign o_push      = fire && !drop;
    assign o_desc.hdr  = hdr;
    assign o_desc.code = code;
    assign o_desc.seq  = r_seq;
    assign o_desc.data = i_data_byte;
    assign o_desc.pend = pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= 16'd0;
            r_bytes_left <= '0;
            r_fill       <= 16'd0;
            r_split      <= 1'b0;
            r_first      <= 1'b0;
        end else if (fire && !drop) begin
            r_bytes_left <= bl_cur - LENGTH_WIDTH'(1);
            r_split      <= split_cur;
            if (pend) begin
                r_fill  <= 16'd0;
                r_first <= 1'b0;
                r_seq   <= r_seq + 16'd1;
            end else begin
                r_fill  <= fill_cur + 16'd1;
                r_first <= first_cur;
            end
        end
    end

endmodule

// File: src/usdu_queue.sv
// ---------------------------------------------------------------------------
// usdu_queue
// Short descriptor queue between classifier and emitter.
// ---------------------------------------------------------------------------
module usdu_queue
    import usdu_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    output logic  o_valid,
    output t_desc o_desc,
    input  logic  i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    t_desc         r_head;
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW-1:0] n_rptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_head;
    assign do_pop  = i_pop && o_valid;
    assign n_rptr  = !do_pop ? r_rptr
                   : ((r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1));

    // hold the next head item in a register; take it straight from the input
    // when it is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
        if (i_push && (r_wptr == n_rptr)) begin
            r_head <= i_desc;
        end else begin
            r_head <= r_mem[n_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            r_rptr <= n_rptr;
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: src/usdu_back.sv
// ---------------------------------------------------------------------------
// usdu_back
// Expands each descriptor into its header bytes (when it opens a PDU) and
// its payload byte through an output register.
// ---------------------------------------------------------------------------
module usdu_back
    import usdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_desc_valid,
    input  t_desc      i_desc,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_pdu_end,
    output logic       o_run_end
);

`include "unack_mode_sdu_segmenter_assert.svh"

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_pend;
    logic       r_rend;
    logic       ld;
    logic       last;
    logic [7:0] sel_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        ld      = i_desc_valid && (!r_valid || i_out_ready);
        last    = !i_desc.hdr || (r_phase == PH_DATA);
        n_phase = r_phase;
        if (!i_desc.hdr) begin
            sel_byte = i_desc.data;
        end else begin
            case (r_phase)
                PH_CODE:   sel_byte = i_desc.code;
                PH_SEQ_LO: sel_byte = i_desc.seq[7:0];
                PH_SEQ_HI: sel_byte = i_desc.seq[15:8];
                default:   sel_byte = i_desc.data;
            endcase
        end
        if (ld) begin
            case (r_phase)
                PH_CODE:   n_phase = i_desc.hdr ? PH_SEQ_LO : PH_CODE;
                PH_SEQ_LO: n_phase = PH_SEQ_HI;
                PH_SEQ_HI: n_phase = PH_DATA;
                default:   n_phase = PH_CODE;
            endcase
        end
    end

    assign o_pop = ld && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_byte <= sel_byte;
            r_pend <= last && i_desc.pend;
            r_rend <= last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_pdu_end   = r_pend;
    assign o_run_end   = r_rend;

    `USDU_ASSERT_IMP(a_hdr_no_end, r_valid && !r_rend, !r_pend)
    `USDU_ASSERT_IMP(a_mid_item_held, r_phase != PH_CODE, i_desc_valid && i_desc.hdr)
    `USDU_ASSERT_NXT(a_pop_ends_run, o_pop, r_valid && r_rend)

endmodule

// File: src/unack_mode_sdu_segmenter.sv
// ---------------------------------------------------------------------------
// unack_mode_sdu_segmenter
// Cuts service data units into PDUs with a three-byte header (framing code,
// sequence number low byte first).
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid/o_in_ready, data, sdu_length   | input
//   out     | o_out_valid/i_out_ready, byte, ends       | output
//   cfg     | i_cfg_we, i_cfg_index, i_cfg_wdata        | input
//
// A byte inside a PDU passes through the queue and the output register; a
// byte that opens a PDU yields four output bytes from the single emitter
// output register. Input takes one byte per cycle while the descriptor queue
// has room. Synchronous active-low reset clears state and restores the
// configuration defaults; no clearing pass. Either side may stall freely.
// ---------------------------------------------------------------------------
module unack_mode_sdu_segmenter
    import usdu_pkg::*;
#(
    parameter int LENGTH_WIDTH = DEF_LENGTH_WIDTH,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    input  logic [15:0]           i_sdu_length,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_pdu_end,
    output logic                  o_run_end
);

    logic  push;
    t_desc push_desc;
    logic  q_ready;
    logic  q_valid;
    t_desc q_desc;
    logic  pop;

    usdu_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_sdu_length (i_sdu_length),
        .o_push       (push),
        .o_desc       (push_desc),
        .i_q_ready    (q_ready)
    );

    usdu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (pop)
    );

    usdu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (q_valid),
        .i_desc       (q_desc),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_pdu_end    (o_pdu_end),
        .o_run_end    (o_run_end)
    );

endmodule

// File: tb/unack_mode_sdu_segmenter_test.sv
// ---------------------------------------------------------------------------
// unack_mode_sdu_segmenter_test
// Self-checking bench for the SDU segmenter. A scoreboard class predicts every
// PDU byte (header code, sequence number, payload, end flags) from the
// accepted input bytes and compares each output byte in order. Directed units
// cover complete, split, zero-length and mid-unit payload changes; random
// phases reconfigure the block between bursts of units under random
// back-pressure, a long receiver hold-off fills the block, and a run at a
// payload of one byte sends one PDU per byte.
// ---------------------------------------------------------------------------
module unack_mode_sdu_segmenter_test;
    import usdu_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 440;
    localparam int ONE_BYTE_ITEMS = 30;
    localparam int TAIL_ITEMS    = 20;
    localparam int REPORT_CAP    = 40;
    localparam int FIRST_SPARE_IDX = int'(CFG_CODE_LAST) + 1;
    localparam int LAST_IDX        = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic [7:0] octet;
        logic       pdu_end;
        logic       run_end;
    } t_pdu_octet;

    class pdu_tracker;
        logic [15:0] max_payload;
        logic [7:0]  code_complete;
        logic [7:0]  code_first;
        logic [7:0]  code_middle;
        logic [7:0]  code_last;
        logic [15:0] seq_num;
        logic [15:0] bytes_left;
        logic [15:0] seg_fill;
        logic        split;
        logic        first_seg;
        t_pdu_octet  due[$];
        int          mismatches;

        function new();
            max_payload   = RST_MAX_PAYLOAD;
            code_complete = RST_CODE_COMPLETE;
            code_first    = RST_CODE_FIRST;
            code_middle   = RST_CODE_MIDDLE;
            code_last     = RST_CODE_LAST;
            seq_num       = '0;
            bytes_left    = '0;
            seg_fill      = '0;
            split         = 1'b0;
            first_seg     = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_MAX_PAYLOAD:   max_payload   = value;
                CFG_CODE_COMPLETE: code_complete = value[7:0];
                CFG_CODE_FIRST:    code_first    = value[7:0];
                CFG_CODE_MIDDLE:   code_middle   = value[7:0];
                CFG_CODE_LAST:     code_last     = value[7:0];
                default: ;
            endcase
        endfunction

        function void push(logic [7:0] b, logic pe, logic re);
            t_pdu_octet o;
            o.octet   = b;
            o.pdu_end = pe;
            o.run_end = re;
            due.insert(due.size(), o);
        endfunction

        function void take_sdu_byte(logic [7:0] data, logic [15:0] sdu_len);
            logic [16:0] limit;
            logic [7:0]  code;
            logic        pend;
            limit = (max_payload == 16'd0) ? 17'd1 : {1'b0, max_payload};
            if (bytes_left == 16'd0) begin
                if (sdu_len == 16'd0)
                    return;
                bytes_left = sdu_len;
                seg_fill   = '0;
                split      = {1'b0, sdu_len} > limit;
                first_seg  = 1'b1;
            end
            if (seg_fill == 16'd0) begin
                if (!split)
                    code = code_complete;
                else if (first_seg)
                    code = code_first;
                else if ({1'b0, bytes_left} <= limit)
                    code = code_last;
                else
                    code = code_middle;
                push(code, 1'b0, 1'b0);
                push(seq_num[7:0], 1'b0, 1'b0);
                push(seq_num[15:8], 1'b0, 1'b0);
            end
            pend = (bytes_left == 16'd1) || ({1'b0, seg_fill} + 17'd1 >= limit);
            push(data, pend, 1'b1);
            bytes_left = bytes_left - 16'd1;
            seg_fill   = seg_fill + 16'd1;
            if (pend) begin
                seg_fill  = '0;
                first_seg = 1'b0;
                seq_num   = seq_num + 16'd1;
            end
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            if (mismatches < REPORT_CAP)
                $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
            mismatches++;
        endtask

        task match_pdu_byte(logic [7:0] b, logic pe, logic re);
            t_pdu_octet want;
            if (due.size() == 0) begin
                report("out_byte with nothing due", {8'd0, b}, '0);
                return;
            end
            want = due.pop_front();
            if (b !== want.octet)
                report("out_byte", {8'd0, b}, {8'd0, want.octet});
            if (pe !== want.pdu_end)
                report("pdu_end", {15'd0, pe}, {15'd0, want.pdu_end});
            if (re !== want.run_end)
                report("run_end", {15'd0, re}, {15'd0, want.run_end});
        endtask

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte;
    logic [15:0]           i_sdu_length;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [7:0]            o_out_byte;
    logic                  o_pdu_end;
    logic                  o_run_end;

    pdu_tracker tracker = new();
    int         unit_left   = 0;
    int         burst_left  = 0;
    int         stuck_cycles = 0;
    logic       tx_quiet = 1'b0;
    logic       rx_quiet = 1'b0;
    logic       hold_req = 1'b0;

    unack_mode_sdu_segmenter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_sdu_length (i_sdu_length),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_pdu_end    (o_pdu_end),
        .o_run_end    (o_run_end)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            tracker.take_sdu_byte(i_data_byte, i_sdu_length);
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.match_pdu_byte(o_out_byte, o_pdu_end, o_run_end);
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : receiver
        int   run_left;
        logic level;
        run_left    = 0;
        level       = 1'b1;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_quiet) begin
                i_out_ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    level    = ($urandom_range(0, 3) != 0);
                    run_left = $urandom_range(1, 8);
                end
                i_out_ready = level;
                run_left--;
            end
        end
    end

    // length field only matters on the byte that opens a unit
    task automatic send_sdu_byte(input logic [7:0] d, input logic [15:0] open_len);
        logic [15:0] len_field;
        int          gap;
        if (unit_left == 0) begin
            len_field = open_len;
            unit_left = open_len;
        end else begin
            len_field = 16'($urandom_range(0, 65535));
        end
        if (unit_left != 0)
            unit_left--;
        if (!tx_quiet) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 12);
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_data_byte  = d;
        i_sdu_length = len_field;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value;
        tracker.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          counted;
        int          n;
        int          r;
        logic [15:0] open_len;
        logic [15:0] maxp;
        logic        quiet;
        logic        hold_done;

        counted      = 0;
        hold_done    = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_MAX_PAYLOAD;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_sdu_length = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: complete units, then a dropped zero-length byte
        send_sdu_byte(8'h00, 16'd1);
        send_sdu_byte(8'hFF, 16'd3);
        send_sdu_byte(8'h00, 16'd3);
        send_sdu_byte(8'hFF, 16'd3);
        send_sdu_byte(8'h5A, 16'd0);
        drain();

        // one-byte payload: first, middle, last
        write_reg(CFG_MAX_PAYLOAD, 16'd1);
        write_reg(CFG_CODE_COMPLETE, 16'hFFFF);
        write_reg(CFG_CODE_FIRST, 16'h0000);
        write_reg(CFG_CODE_MIDDLE, 16'h00A5);
        write_reg(CFG_CODE_LAST, 16'h005A);
        for (int i = FIRST_SPARE_IDX; i <= LAST_IDX; i++)
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
        send_sdu_byte(8'hFF, 16'd3);
        send_sdu_byte(8'h00, 16'd3);
        send_sdu_byte(8'hFF, 16'd3);
        drain();

        // zero payload limit behaves as one
        write_reg(CFG_MAX_PAYLOAD, 16'd0);
        send_sdu_byte(8'h00, 16'd2);
        send_sdu_byte(8'hFF, 16'd2);
        drain();

        // payload limit changed part way through a unit
        write_reg(CFG_MAX_PAYLOAD, 16'd4);
        write_reg(CFG_CODE_FIRST, 16'h00FF);
        write_reg(CFG_CODE_MIDDLE, 16'h000F);
        write_reg(CFG_CODE_LAST, 16'h00F0);
        repeat (5) send_sdu_byte(8'($urandom_range(0, 255)), 16'd10);
        drain();
        write_reg(CFG_MAX_PAYLOAD, 16'd1);
        send_sdu_byte(8'h00, 16'd0);
        drain();
        write_reg(CFG_MAX_PAYLOAD, 16'd3);
        repeat (4) send_sdu_byte(8'($urandom_range(0, 255)), 16'd0);
        drain();

        // largest payload limit
        write_reg(CFG_MAX_PAYLOAD, 16'hFFFF);
        write_reg(CFG_CODE_COMPLETE, 16'h0000);
        write_reg(CFG_CODE_LAST, 16'h00FF);
        send_sdu_byte(8'h00, 16'd5);
        send_sdu_byte(8'hFF, 16'd5);
        send_sdu_byte(8'h00, 16'd5);
        send_sdu_byte(8'hFF, 16'd5);
        send_sdu_byte(8'h80, 16'd5);
        drain();

        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                maxp = 16'd0;
            else if (r < 10)
                maxp = 16'hFFFF;
            else if (r < 25)
                maxp = 16'd1;
            else if (r < 75)
                maxp = 16'($urandom_range(2, 8));
            else
                maxp = 16'($urandom_range(9, 40));
            write_reg(CFG_MAX_PAYLOAD, maxp);
            write_reg(CFG_CODE_COMPLETE, 16'($urandom_range(0, 65535)));
            write_reg(CFG_CODE_FIRST, 16'($urandom_range(0, 65535)));
            write_reg(CFG_CODE_MIDDLE, 16'($urandom_range(0, 65535)));
            write_reg(CFG_CODE_LAST, 16'($urandom_range(0, 65535)));
            quiet    = ($urandom_range(0, 4) == 0);
            tx_quiet = quiet;
            rx_quiet = quiet;
            n = $urandom_range(4, 40);
            repeat (n) begin
                if (counted >= 150 && !hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 6)
                    open_len = 16'd0;
                else if (r < 80)
                    open_len = 16'($urandom_range(1, 12));
                else if (r < 97)
                    open_len = 16'($urandom_range(13, 48));
                else
                    open_len = 16'($urandom_range(49, 400));
                if (unit_left != 0 || open_len != 16'd0)
                    counted++;
                send_sdu_byte(8'($urandom_range(0, 255)), open_len);
            end
            drain();
        end

        // one PDU per byte, back to back
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        write_reg(CFG_MAX_PAYLOAD, 16'd1);
        repeat (ONE_BYTE_ITEMS)
            send_sdu_byte(8'($urandom_range(0, 255)), 16'($urandom_range(1, 12)));
        while (unit_left != 0)
            send_sdu_byte(8'($urandom_range(0, 255)), 16'd0);
        drain();

        // open the longest unit and send its first bytes
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        write_reg(CFG_MAX_PAYLOAD, 16'd3);
        repeat (TAIL_ITEMS) send_sdu_byte(8'($urandom_range(0, 255)), 16'hFFFF);
        drain();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/usdu_pkg.sv
src/usdu_front.sv
src/usdu_queue.sv
src/usdu_back.sv
src/unack_mode_sdu_segmenter.sv
tb/unack_mode_sdu_segmenter_test.sv
